@@ rtl/core/mepc_pkg.sv @@
// Shared types and constants of the Mandelbrot escape and period classifier.
package mepc_pkg;

    // Fixed-point format of the point and of the orbit values.
    localparam int unsigned C_W    = 48;
    localparam int unsigned FRAC   = 44;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned LIMIT_W    = 16;
    localparam int unsigned TOL_W      = 20;

    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_SQ     = 1'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10000;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 20'd18;

    // Result fields.
    localparam int unsigned OUTCOME_W = 2;
    localparam int unsigned STEP_W    = 16;
    localparam int unsigned PERIOD_W  = 5;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_ESCAPED   = 2'd0,
        OUT_PERIODIC  = 2'd1,
        OUT_UNDECIDED = 2'd2
    } t_outcome;

endpackage

@@ rtl/core/mepc_in_if.sv @@
// Point channel of the classifier: valid, ready and the point c.
interface mepc_in_if import mepc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [C_W-1:0]   c_real;
    logic signed [C_W-1:0]   c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

@@ rtl/core/mepc_out_if.sv @@
// Result channel of the classifier: valid, ready and the classification.
interface mepc_out_if import mepc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OUTCOME_W-1:0]   outcome;
    logic [STEP_W-1:0]      escape_step;
    logic [PERIOD_W-1:0]    cycle_length;

    modport source (output valid, output outcome, output escape_step, output cycle_length,
                    input ready);
    modport sink   (input valid, input outcome, input escape_step, input cycle_length,
                    output ready);
endinterface

@@ rtl/core/mandelbrot_escape_period_classifier.sv @@
// Mandelbrot escape-time classifier with periodic-orbit detection on a shared multiplier.
// The block takes one point c (signed Q4.44) at a time and iterates z = z*z + c from
// z = 0, at most iteration_limit steps. Each step runs the cross product and the two
// squares of the new z, each as four 32x32 partial products through the one multiplier,
// then compares the new z with up to HISTORY history entries, with a shorter path when
// an entry is far away. The result goes to an output register, so the next point is
// taken while the previous result waits. Squares of the new z are kept and serve as
// z*z of the next step. No clearing pass is needed after reset.
module mandelbrot_escape_period_classifier
    import mepc_pkg::*;
#(
    parameter int unsigned HISTORY = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mepc_in_if.sink               i_pt,
    mepc_out_if.source            o_res
);

    localparam int unsigned HW = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int unsigned KW = $clog2(HISTORY + 1);
    localparam int unsigned ZW = 50;          // new orbit values before the escape test
    localparam int unsigned MW = 48;          // operand magnitude of the wide multiply
    localparam int unsigned AW = 2 * MW;      // accumulator of the wide multiply
    localparam int unsigned SQW = AW - FRAC;  // truncated square
    localparam int unsigned DW = 51;          // distance to a history entry
    localparam logic [SQW:0] ESC_LIMIT = (SQW+1)'(4) << FRAC;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_MUL, S_MWAIT, S_NI, S_SQR, S_SQI,
        S_CRD, S_CDIF, S_CSQ0, S_CSQ1, S_CCMP, S_PUSH, S_DONE
    } t_state;

    t_state                  r_state;
    t_state                  r_ret;
    logic [LIMIT_W-1:0]      r_limit;
    logic [TOL_W-1:0]        r_tol;

    logic signed [C_W-1:0]   r_cr;
    logic signed [C_W-1:0]   r_ci;
    logic signed [ZW-1:0]    r_nr;
    logic signed [ZW-1:0]    r_ni;
    logic [SQW-1:0]          r_sqr;
    logic [SQW-1:0]          r_sqi;
    logic [LIMIT_W-1:0]      r_step;
    logic [KW-1:0]           r_fill;
    logic [KW-1:0]           r_k;
    logic [HW-1:0]           r_head;
    logic [HW-1:0]           r_slot;

    // Shared multiplier and its accumulator.
    logic [MW-1:0]           r_ma;
    logic [MW-1:0]           r_mb;
    logic                    r_neg;
    logic [1:0]              r_pp;
    logic [1:0]              r_prod_pp;
    logic                    r_issue;
    logic [63:0]             r_prod;
    logic [AW-1:0]           r_acc;

    // History compare.
    logic [2*C_W-1:0]        r_rd;
    logic [31:0]             r_dr_mag;
    logic [31:0]             r_di_mag;
    logic                    r_far;
    logic [TOL_W-1:0]        r_dsq;

    // Pending and registered result.
    t_outcome                r_outc;
    logic [STEP_W-1:0]       r_esc;
    logic [PERIOD_W-1:0]     r_per;
    logic                    r_out_valid;
    t_outcome                r_out_outc;
    logic [STEP_W-1:0]       r_out_esc;
    logic [PERIOD_W-1:0]     r_out_per;

    logic [2*C_W-1:0]        r_hist [HISTORY];

    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [63:0]             w_prod;
    logic [6:0]              w_acc_sh;
    logic signed [AW:0]      w_cross;
    logic signed [AW:0]      w_cross_sh;
    logic signed [ZW-1:0]    n_nr;
    logic signed [ZW-1:0]    n_ni;
    logic [MW-1:0]           w_abs_nr;
    logic [MW-1:0]           w_abs_ni;
    logic [MW-1:0]           w_abs_zr;
    logic [MW-1:0]           w_abs_zi;
    logic [SQW:0]            w_norm;
    logic signed [DW-1:0]    w_dr;
    logic signed [DW-1:0]    w_di;
    logic [DW-1:0]           w_dr_abs;
    logic [DW-1:0]           w_di_abs;
    logic [TOL_W:0]          w_dist;
    logic [HW-1:0]           n_slot_first;
    logic [HW-1:0]           n_slot_next;
    logic [HW-1:0]           n_head;
    logic [LIMIT_W:0]        n_step;

    // Operand selection of the shared 32x32 multiplier.
    always_comb begin
        case (r_state)
            S_MUL: begin
                mul_a = r_pp[1] ? 32'(r_ma[MW-1:32]) : r_ma[31:0];
                mul_b = r_pp[0] ? 32'(r_mb[MW-1:32]) : r_mb[31:0];
            end
            S_CSQ0: begin
                mul_a = r_dr_mag;
                mul_b = r_dr_mag;
            end
            S_CSQ1: begin
                mul_a = r_di_mag;
                mul_b = r_di_mag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign w_prod   = mul_a * mul_b;
    assign w_acc_sh = {r_prod_pp[1] & r_prod_pp[0], r_prod_pp[1] ^ r_prod_pp[0], 5'd0};

    // The cross term is 2*zr*zi floored to 44 fractional bits.
    assign w_cross    = r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
    assign w_cross_sh = w_cross >>> (FRAC - 1);
    assign n_ni = ZW'(w_cross_sh) + {{(ZW-C_W){r_ci[C_W-1]}}, r_ci};
    assign n_nr = $signed(ZW'(r_sqr)) - $signed(ZW'(r_sqi))
                + {{(ZW-C_W){r_cr[C_W-1]}}, r_cr};

    assign w_abs_zr = MW'(r_nr[ZW-1] ? -r_nr : r_nr);
    assign w_abs_zi = MW'(r_ni[ZW-1] ? -r_ni : r_ni);
    assign w_abs_nr = w_abs_zr;
    assign w_abs_ni = w_abs_zi;

    assign w_norm = {1'b0, r_sqr} + {1'b0, r_acc[AW-1:FRAC]};

    assign w_dr = $signed({{(DW-C_W){r_rd[C_W-1]}}, r_rd[C_W-1:0]})
                - $signed({{(DW-ZW){r_nr[ZW-1]}}, r_nr});
    assign w_di = $signed({{(DW-C_W){r_rd[2*C_W-1]}}, r_rd[2*C_W-1:C_W]})
                - $signed({{(DW-ZW){r_ni[ZW-1]}}, r_ni});
    assign w_dr_abs = w_dr[DW-1] ? DW'(-w_dr) : DW'(w_dr);
    assign w_di_abs = w_di[DW-1] ? DW'(-w_di) : DW'(w_di);

    assign w_dist = {1'b0, r_dsq} + {1'b0, r_prod[63:FRAC]};

    assign n_slot_first = (r_head == '0) ? HW'(HISTORY - 1) : r_head - 1'b1;
    assign n_slot_next  = (r_slot == '0) ? HW'(HISTORY - 1) : r_slot - 1'b1;
    assign n_head       = (r_head == HW'(HISTORY - 1)) ? '0 : r_head + 1'b1;
    assign n_step       = {1'b0, r_step} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_NI;
            r_limit     <= LIMIT_RESET;
            r_tol       <= TOL_RESET;
            r_issue     <= 1'b0;
            r_pp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ITER_LIMIT: r_limit <= LIMIT_W'(i_cfg_data);
                    REG_TOL_SQ:     r_tol   <= TOL_W'(i_cfg_data);
                    default: ;
                endcase
            end

            // A finished point reloads the output register itself.
            if (o_res.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            r_prod  <= w_prod;
            r_issue <= (r_state == S_MUL);
            if (r_issue) begin
                r_acc <= r_acc + (AW'(r_prod) << w_acc_sh);
            end

            case (r_state)
                S_IDLE: begin
                    if (i_pt.valid) begin
                        r_cr   <= i_pt.c_real;
                        r_ci   <= i_pt.c_imag;
                        r_nr   <= '0;
                        r_ni   <= '0;
                        r_sqr  <= '0;
                        r_sqi  <= '0;
                        r_step <= '0;
                        r_fill <= '0;
                        r_head <= '0;
                        if (r_limit == '0) begin
                            r_outc  <= OUT_UNDECIDED;
                            r_esc   <= '0;
                            r_per   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    // Real part from the squares kept by the previous step.
                    r_ma    <= w_abs_zr;
                    r_mb    <= w_abs_zi;
                    r_neg   <= r_nr[ZW-1] ^ r_ni[ZW-1];
                    r_nr    <= n_nr;
                    r_acc   <= '0;
                    r_pp    <= '0;
                    r_ret   <= S_NI;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod_pp <= r_pp;
                    r_pp      <= r_pp + 1'b1;
                    if (r_pp == 2'd3) begin
                        r_state <= S_MWAIT;
                    end
                end
                S_MWAIT: begin
                    r_state <= r_ret;
                end
                S_NI: begin
                    r_ni    <= n_ni;
                    r_ma    <= w_abs_nr;
                    r_mb    <= w_abs_nr;
                    r_acc   <= '0;
                    r_ret   <= S_SQR;
                    r_state <= S_MUL;
                end
                S_SQR: begin
                    r_sqr   <= r_acc[AW-1:FRAC];
                    r_ma    <= w_abs_ni;
                    r_mb    <= w_abs_ni;
                    r_acc   <= '0;
                    r_ret   <= S_SQI;
                    r_state <= S_MUL;
                end
                S_SQI: begin
                    r_sqi <= r_acc[AW-1:FRAC];
                    if (w_norm >= ESC_LIMIT) begin
                        r_outc  <= OUT_ESCAPED;
                        r_esc   <= r_step;
                        r_per   <= '0;
                        r_state <= S_DONE;
                    end else if (r_fill == '0) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_k     <= KW'(1);
                        r_slot  <= n_slot_first;
                        r_state <= S_CRD;
                    end
                end
                S_CRD: begin
                    r_state <= S_CDIF;
                end
                S_CDIF: begin
                    r_dr_mag <= w_dr_abs[31:0];
                    r_di_mag <= w_di_abs[31:0];
                    // A component at or beyond 2^32 alone exceeds any tolerance.
                    r_far    <= (w_dr_abs[DW-1:32] != '0) || (w_di_abs[DW-1:32] != '0);
                    r_state  <= S_CSQ0;
                end
                S_CSQ0: begin
                    if (r_far) begin
                        if (r_k == r_fill) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_slot  <= n_slot_next;
                            r_state <= S_CRD;
                        end
                    end else begin
                        r_state <= S_CSQ1;
                    end
                end
                S_CSQ1: begin
                    r_dsq   <= r_prod[63:FRAC];
                    r_state <= S_CCMP;
                end
                S_CCMP: begin
                    if (w_dist <= {1'b0, r_tol}) begin
                        r_outc  <= OUT_PERIODIC;
                        r_esc   <= '0;
                        r_per   <= PERIOD_W'(r_k);
                        r_state <= S_DONE;
                    end else if (r_k == r_fill) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_slot  <= n_slot_next;
                        r_state <= S_CRD;
                    end
                end
                S_PUSH: begin
                    r_head <= n_head;
                    if (r_fill != KW'(HISTORY)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_step <= LIMIT_W'(n_step);
                    if (n_step == {1'b0, r_limit}) begin
                        r_outc  <= OUT_UNDECIDED;
                        r_esc   <= '0;
                        r_per   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_START;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_outc  <= r_outc;
                        r_out_esc   <= r_esc;
                        r_out_per   <= r_per;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Orbit history: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH) begin
            r_hist[r_head] <= {C_W'(r_ni), C_W'(r_nr)};
        end
        if (r_state == S_CRD) begin
            r_rd <= r_hist[r_slot];
        end
    end

    assign i_pt.ready         = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.outcome      = r_out_outc;
    assign o_res.escape_step  = r_out_esc;
    assign o_res.cycle_length = r_out_per;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready) |=> (r_state != S_IDLE))
        else $error("accepted point did not start a classification");

    a_issue_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |-> (r_state == S_MUL || r_state == S_MWAIT))
        else $error("partial product accumulated outside a multiply");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_START) |-> (r_fill <= KW'(HISTORY)))
        else $error("history fill count beyond the history depth");

    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.outcome == OUT_ESCAPED || o_res.escape_step == '0) &&
                         (o_res.outcome == OUT_PERIODIC || o_res.cycle_length == '0)))
        else $error("result carries a field that its outcome does not allow");
`endif

endmodule
